@@ rtl/cms_pkg.sv @@
// Package for the counted multiset table: command and status codes,
// transaction field widths, controller state and command types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package cms_pkg;

   // Widths of the transaction fields.
   localparam int OPCODE_W   = 3;
   localparam int KEY_W      = 64;
   localparam int AMOUNT_W   = 16;
   localparam int POSITION_W = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 16;
   localparam int OCC_W      = 7;

   // Command codes.
   localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REDUCE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DIFF   = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd6;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_EXECUTE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request and its match vector
      logic execute;  // update the table and load the response register
   } dp_cmd_type;

endpackage

`default_nettype wire

@@ rtl/cms_if.sv @@
// Valid/ready channel interfaces for the counted multiset table:
// the request channel and the response channel.
// Depends on cms_pkg for the field widths.
`default_nettype none

interface cms_req_if;
   logic                                valid;
   logic                                ready;
   logic [cms_pkg::OPCODE_W-1:0]        opcode;
   logic [cms_pkg::KEY_W-1:0]           key;
   logic [cms_pkg::AMOUNT_W-1:0]        amount;
   logic [cms_pkg::POSITION_W-1:0]      position;

   modport source (output valid, output opcode, output key, output amount,
                   output position, input ready);
   modport sink (input valid, input opcode, input key, input amount,
                 input position, output ready);
endinterface

interface cms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cms_pkg::STATUS_W-1:0]        status;
   logic [cms_pkg::COUNT_W-1:0]         count_after;
   logic [cms_pkg::KEY_W-1:0]           entry_key;
   logic [cms_pkg::OCC_W-1:0]           occupancy;

   modport source (output valid, output status, output count_after,
                   output entry_key, output occupancy, input ready);
   modport sink (input valid, input status, input count_after,
                 input entry_key, input occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/cms_ctrl.sv @@
// Controller of the counted multiset table: accepts a request, sequences
// the execute step and owns the response valid flag.
// Depends on cms_pkg.
`default_nettype none

module cms_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      cms_pkg::dp_cmd_type  cmd
);

   cms_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State and response flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cms_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands. Execution waits while a response is still
   // held in the output register and not being taken. No request is taken
   // while reset is asserted.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         cms_pkg::ST_IDLE: begin
            req_ready = ~reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = cms_pkg::ST_EXECUTE;
            end
         end
         cms_pkg::ST_EXECUTE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cms_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/cms_datapath.sv @@
// Datapath of the counted multiset table: the row of key/count cells with
// parallel compare, the shift that closes a gap, count arithmetic and the
// response register. Depends on cms_pkg.
`default_nettype none

module cms_datapath #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 64,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cms_pkg::dp_cmd_type               cmd,
   input  wire logic [cms_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [cms_pkg::KEY_W-1:0]         req_key,
   input  wire logic [cms_pkg::AMOUNT_W-1:0]      req_amount,
   input  wire logic [cms_pkg::POSITION_W-1:0]    req_position,
   output      logic [cms_pkg::STATUS_W-1:0]      rsp_status,
   output      logic [cms_pkg::COUNT_W-1:0]       rsp_count_after,
   output      logic [cms_pkg::KEY_W-1:0]         rsp_entry_key,
   output      logic [cms_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int TOTAL_BITS = $clog2(CAPACITY + 1);
   localparam logic [TOTAL_BITS-1:0] FULL_TOTAL = TOTAL_BITS'(CAPACITY);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [32:0] COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

   // Table cells; contents above the occupancy are never used.
   logic [KEY_BITS-1:0]   cell_key_ff   [CAPACITY];
   logic [COUNT_BITS-1:0] cell_count_ff [CAPACITY];
   logic [TOTAL_BITS-1:0] total_ff, total_in;

   // Captured request.
   logic [cms_pkg::OPCODE_W-1:0] op_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic [COUNT_BITS-1:0]        amount_ff, amount_in;
   logic [CAPACITY-1:0]          sel_ff, sel_in;

   // Response register.
   logic [cms_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [cms_pkg::COUNT_W-1:0]  count_after_ff;
   logic [cms_pkg::KEY_W-1:0]    entry_key_ff;
   logic [cms_pkg::OCC_W-1:0]    occupancy_ff;

   // Execute-step results.
   logic                  hit;
   logic [KEY_BITS-1:0]   sel_key;
   logic [COUNT_BITS-1:0] sel_count;
   logic [CAPACITY-1:0]   shift_mask;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] new_count, cnt_in;
   logic [KEY_BITS-1:0]   ekey_in;
   logic                  do_write, do_append, do_remove;

   // Amount saturated to the count range.
   always_comb begin
      if (33'(req_amount) > COUNT_MAX_W) begin
         amount_in = COUNT_MAX;
      end else begin
         amount_in = COUNT_BITS'(req_amount);
      end
   end

   // Parallel compare of every occupied cell against the incoming key, or
   // position decode for a read.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (req_opcode == cms_pkg::OP_READ) begin
            sel_in[i] = (i < int'(total_ff)) && (int'(req_position) == i);
         end else begin
            sel_in[i] = (i < int'(total_ff)) &&
                        (cell_key_ff[i] == req_key[KEY_BITS-1:0]);
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         key_ff    <= req_key[KEY_BITS-1:0];
         amount_ff <= amount_in;
         sel_ff    <= sel_in;
      end
   end

   // Selected entry: the match vector is one-hot or empty.
   always_comb begin
      sel_key   = '0;
      sel_count = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_ff[i]) begin
            sel_key   = sel_key | cell_key_ff[i];
            sel_count = sel_count | cell_count_ff[i];
         end
      end
      hit = |sel_ff;
   end

   // Cells at and above the match take their upper neighbor on removal.
   always_comb begin
      shift_mask = sel_ff;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         shift_mask = shift_mask | (shift_mask << s);
      end
   end

   // Command decode and count arithmetic.
   always_comb begin
      sum       = {1'b0, sel_count} + {1'b0, amount_ff};
      new_count = '0;
      cnt_in    = '0;
      ekey_in   = '0;
      status_in = cms_pkg::ST_OK;
      do_write  = 1'b0;
      do_append = 1'b0;
      do_remove = 1'b0;
      total_in  = total_ff;
      unique case (op_ff)
         cms_pkg::OP_FIND: begin
            if (hit) begin
               cnt_in = sel_count;
            end else begin
               status_in = cms_pkg::ST_ABSENT;
            end
         end
         cms_pkg::OP_ADD, cms_pkg::OP_DIFF: begin
            if (!hit) begin
               if (total_ff == FULL_TOTAL) begin
                  status_in = cms_pkg::ST_FULL;
               end else begin
                  do_append = 1'b1;
                  cnt_in    = amount_ff;
                  total_in  = total_ff + TOTAL_BITS'(1);
               end
            end else if (op_ff == cms_pkg::OP_ADD) begin
               new_count = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
               cnt_in    = new_count;
               do_write  = 1'b1;
            end else if (sel_count < amount_ff) begin
               new_count = amount_ff - sel_count;
               cnt_in    = new_count;
               do_write  = 1'b1;
            end else if (sel_count > amount_ff) begin
               new_count = sel_count - amount_ff;
               cnt_in    = new_count;
               do_write  = 1'b1;
            end else begin
               do_remove = 1'b1;
               status_in = cms_pkg::ST_REMOVED;
               total_in  = total_ff - TOTAL_BITS'(1);
            end
         end
         cms_pkg::OP_DELETE: begin
            if (hit) begin
               do_remove = 1'b1;
               status_in = cms_pkg::ST_REMOVED;
               total_in  = total_ff - TOTAL_BITS'(1);
            end else begin
               status_in = cms_pkg::ST_ABSENT;
            end
         end
         cms_pkg::OP_REDUCE: begin
            if (!hit) begin
               status_in = cms_pkg::ST_ABSENT;
            end else if (sel_count > amount_ff) begin
               new_count = sel_count - amount_ff;
               cnt_in    = new_count;
               do_write  = 1'b1;
            end else begin
               do_remove = 1'b1;
               status_in = cms_pkg::ST_REMOVED;
               total_in  = total_ff - TOTAL_BITS'(1);
            end
         end
         cms_pkg::OP_CLEAR: begin
            total_in = '0;
         end
         cms_pkg::OP_READ: begin
            if (hit) begin
               cnt_in  = sel_count;
               ekey_in = sel_key;
            end else begin
               status_in = cms_pkg::ST_ABSENT;
            end
         end
         default: begin
            // Unused code: no change, plain OK response.
         end
      endcase
   end

   // Cell updates: shift down on removal, count write on a match, or
   // append at the tail.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_BITS-1:0]   upper_key;
      logic [COUNT_BITS-1:0] upper_count;

      if (g < CAPACITY - 1) begin : g_upper
         assign upper_key   = cell_key_ff[g+1];
         assign upper_count = cell_count_ff[g+1];
      end else begin : g_top
         assign upper_key   = cell_key_ff[g];
         assign upper_count = cell_count_ff[g];
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            if (do_remove && shift_mask[g]) begin
               cell_key_ff[g]   <= upper_key;
               cell_count_ff[g] <= upper_count;
            end else if (do_write && sel_ff[g]) begin
               cell_count_ff[g] <= new_count;
            end else if (do_append && (int'(total_ff) == g)) begin
               cell_key_ff[g]   <= key_ff;
               cell_count_ff[g] <= amount_ff;
            end
         end
      end
   end

   // Occupancy register.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.execute) begin
         total_ff <= total_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff      <= status_in;
         count_after_ff <= cms_pkg::COUNT_W'(cnt_in);
         entry_key_ff   <= cms_pkg::KEY_W'(ekey_in);
         occupancy_ff   <= cms_pkg::OCC_W'(total_in);
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_count_after = count_after_ff;
   assign rsp_entry_key   = entry_key_ff;
   assign rsp_occupancy   = occupancy_ff;

endmodule

`default_nettype wire

@@ rtl/counted_multiset_table.sv @@
// Counted multiset table: ordered table of distinct keys with saturating
// counts. Top level joining the controller and the datapath.
// Use: each request transaction on req_bus carries an opcode (find, add,
// delete, reduce, difference, clear, read position), a key, an amount and
// a position. Every request yields exactly one response transaction on
// rsp_bus with status, count after the command, entry key and occupancy.
// Both channels use valid/ready; a transaction moves when both are high.
//
// Timing: a request is taken in the idle cycle, where every occupied cell
// compares its key against the request in parallel and the match vector is
// registered. The execute state then runs the command (count update, append
// at the tail, or a shift that closes the gap) and loads the response
// register, following the compare-then-execute sequence of the controller;
// no new request is taken until the last one has executed. The response
// is shown from that register and the next request can be taken while it
// is shown. If the receiver stalls, the held response stays in its register
// and the following request is compared but not executed until that
// response is taken. Reset empties the table at once by clearing the
// occupancy; no request is taken during reset. Depends on cms_pkg, cms_if,
// cms_ctrl and cms_datapath.
`default_nettype none

module counted_multiset_table #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 64,
   parameter int COUNT_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   cms_req_if.sink   req_bus,
   cms_rsp_if.source rsp_bus
);

   cms_pkg::dp_cmd_type cmd;

   // Sequencing and handshake.
   cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Table storage and arithmetic.
   cms_datapath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_bus.opcode),
      .req_key         (req_bus.key),
      .req_amount      (req_bus.amount),
      .req_position    (req_bus.position),
      .rsp_status      (rsp_bus.status),
      .rsp_count_after (rsp_bus.count_after),
      .rsp_entry_key   (rsp_bus.entry_key),
      .rsp_occupancy   (rsp_bus.occupancy)
   );

endmodule

`default_nettype wire
